>>> src/vsd_pkg.sv
`default_nettype none

package vsd_pkg;

  localparam int unsigned SampleW = 16;
  localparam int unsigned CntW    = 13;
  localparam int unsigned SumW    = 29;
  localparam int unsigned SqW     = 44;
  localparam int unsigned OutW    = 25;
  localparam int unsigned IdxW    = 2;
  localparam int unsigned SqPartW = SqW / 2;
  localparam int unsigned NumW    = 60;
  localparam int unsigned NumPosW = 57;
  localparam int unsigned DenW    = 2 * CntW;
  localparam int unsigned FracW   = 16;
  localparam int unsigned DivW    = NumPosW + FracW;
  localparam int unsigned ValW    = 64;
  localparam int unsigned RootW   = ValW / 2;
  localparam int unsigned SremW   = RootW + 2;
  localparam int unsigned StepW   = 7;

  localparam logic [IdxW-1:0] RegVectorLength = 2'd0;
  localparam logic [IdxW-1:0] RegBiasedMode   = 2'd1;
  localparam logic [IdxW-1:0] RegComplexMode  = 2'd2;

  localparam logic [CntW-1:0] VectorLengthRst = 13'd2;

  typedef struct packed {
    logic [CntW-1:0] vector_length;
    logic            biased_mode;
    logic            complex_mode;
  } vsd_cfg_t;

  typedef struct packed {
    logic [CntW-1:0]        n;
    logic signed [SumW-1:0] sum_real;
    logic signed [SumW-1:0] sum_imag;
    logic [SqW-1:0]         sum_sq;
    logic                   biased;
  } vsd_entry_t;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_PROD_LO,
    BK_PROD_HI,
    BK_SQ_RE,
    BK_SQ_IM,
    BK_DEN,
    BK_DIV,
    BK_SQRT,
    BK_OUT
  } vsd_back_state_e;

endpackage

`default_nettype wire

>>> src/vector_standard_deviation.sv
// path from the last sample of a vector to its result: front stage, result queue, back sequencer
// (1 front stage, 5 multiply steps, 73 divide and 32 root iterations, output register)
// throughput: one sample per cycle unless the full result queue holds back the last sample
// of a vector; the bit-serial divider and square root take one vector at a time; length one skips them
// reset: asynchronous active low, clears sums and count, length 2, unbiased, real
`default_nettype none

module vector_standard_deviation #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                cfg_valid_i,
  output logic                                     cfg_ready_o,
  input  wire logic [vsd_pkg::IdxW-1:0]            cfg_index_i,
  input  wire logic [vsd_pkg::CntW-1:0]            cfg_data_i,
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic signed [vsd_pkg::SampleW-1:0]  sample_real_i,
  input  wire logic signed [vsd_pkg::SampleW-1:0]  sample_imag_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [vsd_pkg::OutW-1:0]                 std_dev_o
);
  import vsd_pkg::*;

  vsd_cfg_t   cfg_q;
  logic       push, full, pop, q_valid;
  vsd_entry_t push_data, pop_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.vector_length <= VectorLengthRst;
      cfg_q.biased_mode   <= 1'b0;
      cfg_q.complex_mode  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegVectorLength: cfg_q.vector_length <= cfg_data_i;
        RegBiasedMode:   cfg_q.biased_mode   <= cfg_data_i[0];
        RegComplexMode:  cfg_q.complex_mode  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  vsd_front #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg_q),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .sample_real_i (sample_real_i),
    .sample_imag_i (sample_imag_i),
    .push_o        (push),
    .push_data_o   (push_data),
    .full_i        (full)
  );

  vsd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .full_o      (full),
    .pop_i       (pop),
    .pop_data_o  (pop_data),
    .valid_o     (q_valid)
  );

  vsd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (q_valid),
    .data_i      (pop_data),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .std_dev_o   (std_dev_o)
  );

endmodule

`default_nettype wire

>>> src/vsd_front.sv
`default_nettype none

module vsd_front #(
  parameter int unsigned MAX_LENGTH = 4096
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire vsd_pkg::vsd_cfg_t                    cfg_i,
  input  wire logic                                 in_valid_i,
  output logic                                      in_ready_o,
  input  wire logic signed [vsd_pkg::SampleW-1:0]   sample_real_i,
  input  wire logic signed [vsd_pkg::SampleW-1:0]   sample_imag_i,
  output logic                                      push_o,
  output vsd_pkg::vsd_entry_t                       push_data_o,
  input  wire logic                                 full_i
);
  import vsd_pkg::*;

  localparam logic [16:0] MaxLen = 17'(MAX_LENGTH);

  logic [CntW-1:0]          cnt_q, cnt_d, cnt_inc;
  logic [16:0]              target;
  logic                     last;
  logic                     accept, advance;
  logic signed [SampleW-1:0] xi;
  logic signed [2*SampleW-1:0] pr, pi;

  logic                     a_valid_q;
  logic signed [SampleW-1:0] a_xr_q, a_xi_q;
  logic [2*SampleW:0]       a_sq_q;
  logic                     a_last_q;
  logic [CntW-1:0]          a_n_q;
  logic                     a_biased_q;

  logic signed [SumW-1:0]   sr_q, si_q, sr_new, si_new;
  logic [SqW-1:0]           sq_q, sq_new;

  always_comb begin
    target = {4'b0, cfg_i.vector_length};
    if (target == 17'd0) begin
      target = 17'd1;
    end else if (target > MaxLen) begin
      target = MaxLen;
    end
    cnt_inc = cnt_q + 1'b1;
    last    = (cnt_inc == '0) || ({4'b0, cnt_inc} >= target);
    cnt_d   = last ? '0 : cnt_inc;
  end

  assign xi = cfg_i.complex_mode ? sample_imag_i : '0;
  assign pr = sample_real_i * sample_real_i;
  assign pi = xi * xi;

  assign advance    = a_valid_q && (!a_last_q || !full_i);
  assign in_ready_o = !a_valid_q || advance;
  assign accept     = in_valid_i && in_ready_o;

  // stage a: squares and vector boundary
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      if (accept) begin
        a_valid_q <= 1'b1;
        cnt_q     <= cnt_d;
      end else if (advance) begin
        a_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_xr_q     <= sample_real_i;
      a_xi_q     <= xi;
      a_sq_q     <= (2*SampleW+1)'(unsigned'(pr)) + (2*SampleW+1)'(unsigned'(pi));
      a_last_q   <= last;
      a_n_q      <= cnt_inc;
      a_biased_q <= cfg_i.biased_mode;
    end
  end

  // stage b: running sums
  assign sr_new = sr_q + SumW'(a_xr_q);
  assign si_new = si_q + SumW'(a_xi_q);
  assign sq_new = sq_q + SqW'(a_sq_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sr_q <= '0;
      si_q <= '0;
      sq_q <= '0;
    end else if (advance) begin
      if (a_last_q) begin
        sr_q <= '0;
        si_q <= '0;
        sq_q <= '0;
      end else begin
        sr_q <= sr_new;
        si_q <= si_new;
        sq_q <= sq_new;
      end
    end
  end

  assign push_o               = advance && a_last_q;
  assign push_data_o.n        = a_n_q;
  assign push_data_o.sum_real = sr_new;
  assign push_data_o.sum_imag = si_new;
  assign push_data_o.sum_sq   = sq_new;
  assign push_data_o.biased   = a_biased_q;

endmodule

`default_nettype wire

>>> src/vsd_queue.sv
`default_nettype none

module vsd_queue (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 push_i,
  input  wire vsd_pkg::vsd_entry_t  push_data_i,
  output logic                      full_o,
  input  wire logic                 pop_i,
  output vsd_pkg::vsd_entry_t       pop_data_o,
  output logic                      valid_o
);
  import vsd_pkg::*;

  vsd_entry_t mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q;

  assign full_o     = (count_q == 2'd2);
  assign valid_o    = (count_q != 2'd0);
  assign pop_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

`default_nettype wire

>>> src/vsd_back.sv
`default_nettype none

module vsd_back (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  input  wire vsd_pkg::vsd_entry_t           data_i,
  output logic                               pop_o,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [vsd_pkg::OutW-1:0]           std_dev_o
);
  import vsd_pkg::*;

  vsd_back_state_e state_q, state_d;
  vsd_entry_t      ent_q, ent_d;
  logic [NumW-1:0] num_q, num_d;
  logic [DenW-1:0] den_q, den_d;
  logic [DivW-1:0] dq_q, dq_d;
  logic [DenW-1:0] rem_q, rem_d;
  logic [StepW-1:0] cnt_q, cnt_d;
  logic [ValW-1:0] val_q, val_d;
  logic [RootW-1:0] root_q, root_d;
  logic [SremW-1:0] srem_q, srem_d;
  logic            out_valid_q, out_valid_d;
  logic [OutW-1:0] std_dev_q, std_dev_d;

  logic [CntW+SqPartW-1:0] prod_part;
  logic signed [2*SumW-1:0] sum_sq_prod;
  logic [DenW:0]   rem_sh;
  logic            div_ge;
  logic [SremW+1:0] srem_sh, trial;
  logic            sq_ge;
  logic [CntW-1:0] n_m1;
  logic [NumPosW-1:0] num_pos;

  always_comb begin
    state_d     = state_q;
    ent_d       = ent_q;
    num_d       = num_q;
    den_d       = den_q;
    dq_d        = dq_q;
    rem_d       = rem_q;
    cnt_d       = cnt_q;
    val_d       = val_q;
    root_d      = root_q;
    srem_d      = srem_q;
    out_valid_d = out_valid_q;
    std_dev_d   = std_dev_q;
    pop_o       = 1'b0;

    prod_part   = '0;
    sum_sq_prod = '0;
    n_m1        = ent_q.n - 1'b1;
    num_pos     = num_q[NumW-1] ? '0 : num_q[NumPosW-1:0];

    rem_sh  = {rem_q, dq_q[DivW-1]};
    div_ge  = rem_sh >= {1'b0, den_q};
    srem_sh = {srem_q, val_q[ValW-1 -: 2]};
    trial   = {2'b00, root_q, 2'b01};
    sq_ge   = srem_sh >= trial;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      BK_IDLE: begin
        if (valid_i) begin
          pop_o = 1'b1;
          ent_d = data_i;
          num_d = '0;
          if (data_i.n < CntW'(2)) begin
            root_d  = '0;
            state_d = BK_OUT;
          end else begin
            state_d = BK_PROD_LO;
          end
        end
      end
      BK_PROD_LO: begin
        prod_part = ent_q.n * ent_q.sum_sq[SqPartW-1:0];
        num_d     = NumW'(prod_part);
        state_d   = BK_PROD_HI;
      end
      BK_PROD_HI: begin
        prod_part = ent_q.n * ent_q.sum_sq[SqW-1:SqPartW];
        num_d     = num_q + (NumW'(prod_part) << SqPartW);
        state_d   = BK_SQ_RE;
      end
      BK_SQ_RE: begin
        sum_sq_prod = ent_q.sum_real * ent_q.sum_real;
        num_d       = num_q - NumW'(unsigned'(sum_sq_prod));
        state_d     = BK_SQ_IM;
      end
      BK_SQ_IM: begin
        sum_sq_prod = ent_q.sum_imag * ent_q.sum_imag;
        num_d       = num_q - NumW'(unsigned'(sum_sq_prod));
        state_d     = BK_DEN;
      end
      BK_DEN: begin
        den_d   = ent_q.n * (ent_q.biased ? ent_q.n : n_m1);
        dq_d    = {num_pos, FracW'(0)};
        rem_d   = '0;
        cnt_d   = '0;
        state_d = BK_DIV;
      end
      BK_DIV: begin
        rem_d = div_ge ? DenW'(rem_sh - {1'b0, den_q}) : DenW'(rem_sh);
        dq_d  = {dq_q[DivW-2:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == StepW'(DivW - 1)) begin
          val_d   = {dq_q[ValW-2:0], div_ge};
          root_d  = '0;
          srem_d  = '0;
          cnt_d   = '0;
          state_d = BK_SQRT;
        end
      end
      BK_SQRT: begin
        srem_d = sq_ge ? SremW'(srem_sh - trial) : SremW'(srem_sh);
        root_d = {root_q[RootW-2:0], sq_ge};
        val_d  = {val_q[ValW-3:0], 2'b00};
        cnt_d  = cnt_q + 1'b1;
        if (cnt_q == StepW'(RootW - 1)) begin
          state_d = BK_OUT;
        end
      end
      BK_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          std_dev_d   = root_q[OutW-1:0];
          state_d     = BK_IDLE;
        end
      end
      default: begin
        state_d = BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ent_q     <= ent_d;
    num_q     <= num_d;
    den_q     <= den_d;
    dq_q      <= dq_d;
    rem_q     <= rem_d;
    cnt_q     <= cnt_d;
    val_q     <= val_d;
    root_q    <= root_d;
    srem_q    <= srem_d;
    std_dev_q <= std_dev_d;
  end

  assign out_valid_o = out_valid_q;
  assign std_dev_o   = std_dev_q;

endmodule

`default_nettype wire
